@@ hw/rtl/fuel_cell_charger_sequencer_assert.svh @@
// Assertion macros for the sequencer RTL.
`ifndef FUEL_CELL_CHARGER_SEQUENCER_ASSERT_SVH
`define FUEL_CELL_CHARGER_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FCCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fccs assertion failed");

// Next-cycle implication, checked out of reset.
`define FCCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fccs assertion failed");

`endif

@@ hw/rtl/fccs_pkg.sv @@
`timescale 1ns / 1ps

package fccs_pkg;

    localparam logic [2:0] ST_POWERUP   = 3'd0;
    localparam logic [2:0] ST_STANDBY   = 3'd1;
    localparam logic [2:0] ST_STARTUP   = 3'd2;
    localparam logic [2:0] ST_READY     = 3'd3;
    localparam logic [2:0] ST_CHG_START = 3'd4;
    localparam logic [2:0] ST_CHARGING  = 3'd5;
    localparam logic [2:0] ST_SHUTDOWN  = 3'd6;
    localparam logic [2:0] ST_WAIT      = 3'd7;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_STARTUP   = 3'd1;
    localparam logic [2:0] OP_SHUTDOWN  = 3'd2;
    localparam logic [2:0] OP_START_CHG = 3'd3;
    localparam logic [2:0] OP_STOP_CHG  = 3'd4;
    localparam logic [2:0] OP_EMERGENCY = 3'd5;

    localparam logic [2:0] REG_CURRENT_MIN     = 3'd0;
    localparam logic [2:0] REG_CURRENT_MAX     = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP       = 3'd2;
    localparam logic [2:0] REG_VOLT_SETTLE     = 3'd3;
    localparam logic [2:0] REG_SETTLE_DELAY    = 3'd4;
    localparam logic [2:0] REG_SHUTDOWN_DELAY  = 3'd5;
    localparam logic [2:0] REG_ERR_EN_DELAY    = 3'd6;
    localparam logic [2:0] REG_STARTUP_TIMEOUT = 3'd7;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [15:0] current_min;
        logic [15:0] current_max;
        logic [15:0] ramp_step;
        logic [15:0] volt_settle_threshold;
        logic [31:0] settle_delay_ms;
        logic [31:0] shutdown_delay_ms;
        logic [31:0] error_enable_delay_ms;
        logic [31:0] startup_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  current_state;
        logic [2:0]  wait_next_state;
        logic [31:0] wait_start_time;
        logic [31:0] wait_length;
        logic [31:0] entry_time;
        logic [15:0] previous_voltage;
        logic [15:0] current_ref;
    } seq_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic        connection_ok;
        logic        cell_running;
        logic        error_present;
        logic        battery_full;
        logic [15:0] voltage_in;
    } item_t;

    typedef struct packed {
        logic [2:0]  state_code;
        logic        cell_start;
        logic        cell_stop;
        logic        cell_errors_enable;
        logic        relay_on;
        logic        relay_off;
        logic        conv_start;
        logic        conv_stop;
        logic [15:0] current_ref_out;
        logic        current_ref_write;
        logic        startup_failed;
    } result_t;

endpackage

@@ hw/rtl/fuel_cell_charger_sequencer.sv @@
`timescale 1ns / 1ps
`include "fuel_cell_charger_sequencer_assert.svh"

// Supervisory sequencer of a fuel-cell charger.
// Input words (s_*) carry one event: s_tuser holds the operation code, s_tdata
// the timestamp, status flags and input voltage. Each event gives exactly one
// result word (m_*) with the new state, one-word action strobes and the
// current reference.
// Configuration writes come on cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. Write only while no event is in flight.
// The event register feeds one pass of state-update logic into the result
// register, which drives m_tdata. Throughput: one word per cycle while the
// receiver takes each result word.
// If m_tready is low the result word holds and the event register fills;
// s_tready then drops until the result word is taken.
// Reset puts the sequencer in powerup with the register defaults loaded and
// both word registers empty.
module fuel_cell_charger_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [55:52] zero, [51:36] voltage_in, [35] battery_full, [34] error_present,
    // [33] cell_running, [32] connection_ok, [31:0] now_ms
    input  logic [fccs_pkg::IN_TDATA_W-1:0]   s_tdata,
    // [2:0] operation
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:28] zero, [27] startup_failed, [26] current_ref_write,
    // [25:10] current_ref_out, [9] conv_stop, [8] conv_start, [7] relay_off,
    // [6] relay_on, [5] cell_errors_enable, [4] cell_stop, [3] cell_start,
    // [2:0] state_code
    output logic [fccs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import fccs_pkg::*;

    cfg_t       cfg;
    item_t      item_reg;
    logic       item_valid_reg;
    seq_state_t st_reg;
    seq_state_t st_next;
    result_t    res_next;
    result_t    res_reg;
    logic       res_valid_reg;
    logic       fire;
    logic       s_accept;

    assign cfg_ready = 1'b1;

    fccs_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fccs_step u_step
    (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    assign fire     = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.operation       <= s_tuser;
            item_reg.now_ms          <= s_tdata[31:0];
            item_reg.connection_ok   <= s_tdata[32];
            item_reg.cell_running    <= s_tdata[33];
            item_reg.error_present   <= s_tdata[34];
            item_reg.battery_full    <= s_tdata[35];
            item_reg.voltage_in      <= s_tdata[51:36];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.current_state    <= ST_POWERUP;
            st_reg.wait_next_state  <= ST_STANDBY;
            st_reg.wait_start_time  <= 32'd0;
            st_reg.wait_length      <= 32'd0;
            st_reg.entry_time       <= 32'd0;
            st_reg.previous_voltage <= 16'd0;
            st_reg.current_ref      <= 16'd0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {4'd0, res_reg.startup_failed, res_reg.current_ref_write,
                       res_reg.current_ref_out, res_reg.conv_stop, res_reg.conv_start,
                       res_reg.relay_off, res_reg.relay_on, res_reg.cell_errors_enable,
                       res_reg.cell_stop, res_reg.cell_start, res_reg.state_code};

    `FCCS_ASSERT_NEXT(a_fire_gives_word, clk, rst_n, fire, m_tvalid)
    `FCCS_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !fire, $stable(st_reg.current_state))
    `FCCS_ASSERT_NOW(a_ref_write_in_ramp, clk, rst_n, m_tvalid && res_reg.current_ref_write,
        res_reg.state_code == ST_CHG_START || res_reg.state_code == ST_CHARGING)
    `FCCS_ASSERT_NOW(a_relay_on_from_startup, clk, rst_n, m_tvalid && res_reg.relay_on,
        res_reg.state_code == ST_WAIT || res_reg.state_code == ST_STANDBY)
    `FCCS_ASSERT_NOW(a_fail_stops_cell, clk, rst_n, m_tvalid && res_reg.startup_failed,
        res_reg.cell_stop && res_reg.state_code == ST_STANDBY)

endmodule

@@ hw/rtl/fccs_cfg.sv @@
`timescale 1ns / 1ps

module fccs_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [2:0]       wr_index,
    input  logic [31:0]      wr_data,
    output fccs_pkg::cfg_t   cfg
);
    import fccs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_min           <= 16'd0;
            cfg_reg.current_max           <= 16'd0;
            cfg_reg.ramp_step             <= 16'd0;
            cfg_reg.volt_settle_threshold <= 16'd10;
            cfg_reg.settle_delay_ms       <= 32'd5000;
            cfg_reg.shutdown_delay_ms     <= 32'd2000;
            cfg_reg.error_enable_delay_ms <= 32'd30000;
            cfg_reg.startup_timeout_ms    <= 32'd45000;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CURRENT_MIN:     cfg_reg.current_min           <= wr_data[15:0];
                REG_CURRENT_MAX:     cfg_reg.current_max           <= wr_data[15:0];
                REG_RAMP_STEP:       cfg_reg.ramp_step             <= wr_data[15:0];
                REG_VOLT_SETTLE:     cfg_reg.volt_settle_threshold <= wr_data[15:0];
                REG_SETTLE_DELAY:    cfg_reg.settle_delay_ms       <= wr_data;
                REG_SHUTDOWN_DELAY:  cfg_reg.shutdown_delay_ms     <= wr_data;
                REG_ERR_EN_DELAY:    cfg_reg.error_enable_delay_ms <= wr_data;
                REG_STARTUP_TIMEOUT: cfg_reg.startup_timeout_ms    <= wr_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/fccs_step.sv @@
`timescale 1ns / 1ps

module fccs_step
(
    input  fccs_pkg::cfg_t       cfg,
    input  fccs_pkg::seq_state_t st,
    input  fccs_pkg::item_t      item,
    output fccs_pkg::seq_state_t st_next,
    output fccs_pkg::result_t    res
);
    import fccs_pkg::*;

    logic [15:0] vdiff;
    logic [31:0] elapsed;
    logic [31:0] wait_elapsed;
    logic [16:0] ramp_sum;
    logic [15:0] ramp_sat;
    logic        stop_cmd;
    logic        tick;
    logic        err;
    logic        fail;

    assign stop_cmd     = (item.operation == OP_SHUTDOWN) || (item.operation == OP_EMERGENCY);
    assign tick         = (item.operation == OP_TICK);
    assign err          = item.error_present;
    assign vdiff        = (item.voltage_in >= st.previous_voltage)
                        ? item.voltage_in - st.previous_voltage
                        : st.previous_voltage - item.voltage_in;
    assign elapsed      = item.now_ms - st.entry_time;
    assign wait_elapsed = item.now_ms - st.wait_start_time;
    assign ramp_sum     = {1'b0, st.current_ref} + {1'b0, cfg.ramp_step};

    always_comb
    begin
        ramp_sat = (ramp_sum > {1'b0, cfg.current_max}) ? cfg.current_max : ramp_sum[15:0];
        if (ramp_sat < cfg.current_min)
        begin
            ramp_sat = cfg.current_min;
        end
    end

    always_comb
    begin
        st_next = st;
        res     = '0;
        fail    = 1'b0;
        res.current_ref_out = 16'd0;

        unique case (st.current_state)
            ST_POWERUP:
            begin
                if (tick && item.connection_ok)
                begin
                    st_next.wait_length     = cfg.settle_delay_ms;
                    st_next.wait_next_state = ST_STANDBY;
                    st_next.wait_start_time = item.now_ms;
                    st_next.current_state   = ST_WAIT;
                    st_next.entry_time      = item.now_ms;
                end
            end
            ST_STANDBY:
            begin
                if ((item.operation == OP_STARTUP || item.operation == OP_START_CHG)
                    && !err && !item.battery_full)
                begin
                    res.cell_start        = 1'b1;
                    st_next.current_state = ST_STARTUP;
                    st_next.entry_time    = item.now_ms;
                end
            end
            ST_STARTUP:
            begin
                if (stop_cmd)
                begin
                    res.cell_stop         = 1'b1;
                    st_next.current_state = ST_STANDBY;
                    st_next.entry_time    = item.now_ms;
                end
                else if (tick)
                begin
                    st_next.previous_voltage = item.voltage_in;
                    if (elapsed > cfg.error_enable_delay_ms)
                    begin
                        res.cell_errors_enable = 1'b1;
                    end
                    if (item.cell_running && vdiff < cfg.volt_settle_threshold)
                    begin
                        res.cell_errors_enable  = 1'b1;
                        res.relay_on            = 1'b1;
                        st_next.wait_length     = cfg.settle_delay_ms;
                        st_next.wait_next_state = ST_READY;
                        st_next.wait_start_time = item.now_ms;
                        st_next.current_state   = ST_WAIT;
                        st_next.entry_time      = item.now_ms;
                    end
                    else if (elapsed > cfg.startup_timeout_ms)
                    begin
                        fail = 1'b1;
                    end
                    // error or timeout falls back to standby, even over the wait
                    if (err || fail)
                    begin
                        res.cell_stop         = 1'b1;
                        st_next.current_state = ST_STANDBY;
                        st_next.entry_time    = item.now_ms;
                    end
                end
            end
            ST_READY:
            begin
                if (stop_cmd || (tick && err))
                begin
                    res.cell_stop           = 1'b1;
                    st_next.wait_length     = cfg.shutdown_delay_ms;
                    st_next.wait_next_state = ST_SHUTDOWN;
                    st_next.wait_start_time = item.now_ms;
                    st_next.current_state   = ST_WAIT;
                    st_next.entry_time      = item.now_ms;
                end
                else if (item.operation == OP_START_CHG && !err && !item.battery_full)
                begin
                    res.conv_start        = 1'b1;
                    st_next.current_state = ST_CHG_START;
                    st_next.entry_time    = item.now_ms;
                end
            end
            ST_CHG_START:
            begin
                if (stop_cmd || (tick && err))
                begin
                    st_next.current_ref     = cfg.current_min;
                    res.conv_stop           = 1'b1;
                    res.cell_stop           = 1'b1;
                    st_next.wait_length     = cfg.shutdown_delay_ms;
                    st_next.wait_next_state = ST_SHUTDOWN;
                    st_next.wait_start_time = item.now_ms;
                    st_next.current_state   = ST_WAIT;
                    st_next.entry_time      = item.now_ms;
                end
                else if (item.operation == OP_STOP_CHG)
                begin
                    res.conv_stop         = 1'b1;
                    st_next.current_ref   = cfg.current_min;
                    st_next.current_state = ST_READY;
                    st_next.entry_time    = item.now_ms;
                end
                else if (tick)
                begin
                    res.current_ref_write = 1'b1;
                    st_next.current_ref   = ramp_sat;
                    if (ramp_sat >= cfg.current_max)
                    begin
                        st_next.current_ref   = cfg.current_min;
                        st_next.current_state = ST_CHARGING;
                        st_next.entry_time    = item.now_ms;
                    end
                end
            end
            ST_CHARGING:
            begin
                if (stop_cmd || (tick && err))
                begin
                    res.conv_stop           = 1'b1;
                    res.cell_stop           = 1'b1;
                    st_next.wait_length     = cfg.shutdown_delay_ms;
                    st_next.wait_next_state = ST_SHUTDOWN;
                    st_next.wait_start_time = item.now_ms;
                    st_next.current_state   = ST_WAIT;
                    st_next.entry_time      = item.now_ms;
                end
                else if (item.operation == OP_STOP_CHG)
                begin
                    res.conv_stop         = 1'b1;
                    st_next.current_state = ST_READY;
                    st_next.entry_time    = item.now_ms;
                end
            end
            ST_SHUTDOWN:
            begin
                if (tick)
                begin
                    res.relay_off         = 1'b1;
                    st_next.current_state = ST_STANDBY;
                    st_next.entry_time    = item.now_ms;
                end
            end
            ST_WAIT:
            begin
                if (stop_cmd)
                begin
                    res.conv_stop = 1'b1;
                end
                else if (tick)
                begin
                    if (wait_elapsed > st.wait_length)
                    begin
                        st_next.current_state = st.wait_next_state;
                        st_next.entry_time    = item.now_ms;
                    end
                    if (err)
                    begin
                        res.conv_stop = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase

        res.startup_failed  = fail;
        res.state_code      = st_next.current_state;
        res.current_ref_out = res.current_ref_write ? ramp_sat : st_next.current_ref;
    end

endmodule
